@@ hw/rtl/round_robin_task_scheduler_core_assert.svh @@
// assertion macros used by the scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check failed");

`endif

@@ hw/rtl/rrts_pkg.sv @@
// ---------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin ready-queue scheduler.
// ---------------------------------------------------------------------------
package rrts_pkg;

  // fixed field widths
  localparam int KIND_W     = 3;
  localparam int TID_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int CPU_OUT_W  = 32;
  localparam int SLICE_W    = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register map, indexed by paddr[2]
  localparam logic REG_SLICE_TICKS = 1'b0;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD          = 3'd0,
    KIND_REMOVE       = 3'd1,
    KIND_PICK         = 3'd2,
    KIND_TICK         = 3'd3,
    KIND_SET_RUN      = 3'd4,
    KIND_RESCHED_SET  = 3'd5,
    KIND_RESCHED_CLR  = 3'd6
  } kind_t;

  // link table control
  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
  } link_ctl_t;

  // cpu time table control
  typedef struct packed {
    logic rd_en;
    logic acc_en;
  } cpu_ctl_t;

  // one result beat
  typedef struct packed {
    logic                 picked_valid;
    logic [TID_W-1:0]     picked_id;
    logic                 op_ignored;
    logic [COUNT_W-1:0]   queued_count;
    logic                 running_valid;
    logic [TID_W-1:0]     running_id;
    logic                 reschedule_pending;
    logic                 slice_expired;
    logic [CPU_OUT_W-1:0] running_cpu_time;
  } result_t;

endpackage

@@ hw/rtl/rrts_if.sv @@
// ---------------------------------------------------------------------------
// rrts_if
// Valid/ready channels of the scheduler: item beats in, result beats out.
// ---------------------------------------------------------------------------
interface rrts_in_if;
  import rrts_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TID_W-1:0]    task_id;
  logic                task_present;

  modport source (output valid, kind, task_id, task_present, input ready);
  modport sink   (input valid, kind, task_id, task_present, output ready);
endinterface

interface rrts_out_if;
  import rrts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 picked_valid;
  logic [TID_W-1:0]     picked_id;
  logic                 op_ignored;
  logic [COUNT_W-1:0]   queued_count;
  logic                 running_valid;
  logic [TID_W-1:0]     running_id;
  logic                 reschedule_pending;
  logic                 slice_expired;
  logic [CPU_OUT_W-1:0] running_cpu_time;

  modport source (output valid, picked_valid, picked_id, op_ignored, queued_count,
                  running_valid, running_id, reschedule_pending, slice_expired,
                  running_cpu_time, input ready);
  modport sink   (input valid, picked_valid, picked_id, op_ignored, queued_count,
                  running_valid, running_id, reschedule_pending, slice_expired,
                  running_cpu_time, output ready);
endinterface

@@ hw/rtl/round_robin_task_scheduler_core.sv @@
// ---------------------------------------------------------------------------
// round_robin_task_scheduler_core
// Round-robin ready-queue scheduler: a doubly linked queue of task numbers
// with a running task, a time-slice counter and per-task cpu time.
//
// Use:
//  - in_ch carries one command beat (kind, task_id, task_present); out_ch
//    returns exactly one result beat for each command.
//  - the APB port holds slice_ticks at byte address 0 (reset value 10);
//    write it only while no command is in flight.
//  - a command is read, then written back: the accept edge reads the link and cpu
//    time memories, and the edge that leaves ST_EXEC with the result register
//    free writes them back and loads the result register, which drives
//    out_ch.valid. A new command is taken only after the write-back of the
//    one in work, so one command is in flight at a time.
//  - the result register parts the channels: a new command is taken while
//    an earlier result still waits. If the receiver stalls, the command in
//    work holds until the result register frees up, and in_ch.ready stays
//    low meanwhile.
//  - after reset the queue is empty, no task runs, all cpu times read zero
//    and the block accepts commands at once.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler_core #(
  parameter int MAX_TASKS     = 16,
  parameter int CPU_TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rrts_in_if.sink                           in_ch,
  rrts_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrts_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rrts_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rrts_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import rrts_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // control state
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] in_queue_r, in_queue_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [IDX_W-1:0]     run_id_r, run_id_nxt;
  logic [SLICE_W-1:0]   slice_cnt_r, slice_cnt_nxt;
  logic                 resched_r, resched_nxt;
  logic [SLICE_W-1:0]   slice_ticks_r;
  logic                 out_valid_r, out_valid_nxt;

  // captured command
  logic [KIND_W-1:0]    kind_r;
  logic [IDX_W-1:0]     tid_r;
  logic                 tid_ok_r;
  logic                 present_r;
  result_t              out_r, res;

  // memory side
  link_ctl_t                link_ctl;
  cpu_ctl_t                 cpu_ctl;
  logic [IDX_W-1:0]         next_raddr, prev_raddr, cpu_raddr;
  logic [IDX_W-1:0]         next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [IDX_W-1:0]         next_rdata, prev_rdata;
  logic [CPU_TIME_BITS-1:0] cur_time, new_time, run_time;

  logic                 in_fire, exec_go, cfg_we;
  logic                 in_tid_ok;
  logic [IDX_W-1:0]     in_idx;
  logic [SLICE_W-1:0]   cnt_inc;
  logic                 expired;

  // command decode at the accept edge
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_tid_ok   = ({{(32-TID_W){1'b0}}, in_ch.task_id} < 32'(MAX_TASKS));
  assign in_idx      = in_tid_ok ? IDX_W'(in_ch.task_id) : '0;

  // memory reads issued with the accept
  assign next_raddr     = (in_ch.kind == KIND_PICK) ? head_r : in_idx;
  assign prev_raddr     = in_idx;
  assign cpu_raddr      = (in_ch.kind == KIND_SET_RUN && in_ch.task_present && in_tid_ok)
                          ? in_idx : run_id_r;

  // the command completes once the result register is free
  assign exec_go = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign cnt_inc = slice_cnt_r + SLICE_W'(1);

  // command execution
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    in_queue_nxt  = in_queue_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    slice_cnt_nxt = slice_cnt_r;
    resched_nxt   = resched_r;
    next_waddr    = tail_r;
    next_wdata    = tid_r;
    prev_waddr    = tid_r;
    prev_wdata    = tail_r;
    link_ctl.rd_en   = in_fire;
    link_ctl.next_we = 1'b0;
    link_ctl.prev_we = 1'b0;
    cpu_ctl.rd_en    = in_fire;
    cpu_ctl.acc_en   = 1'b0;
    expired          = 1'b0;
    res              = '0;

    unique case (kind_r)
      KIND_ADD: begin
        if (!tid_ok_r || in_queue_r[tid_r]) begin
          res.op_ignored = 1'b1;
        end else begin
          // link behind the current tail
          if (count_r == '0) begin
            head_nxt = tid_r;
          end else begin
            link_ctl.next_we = 1'b1;
          end
          link_ctl.prev_we     = 1'b1;
          tail_nxt             = tid_r;
          in_queue_nxt[tid_r]  = 1'b1;
          count_nxt            = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (!tid_ok_r || !in_queue_r[tid_r]) begin
          res.op_ignored = 1'b1;
        end else begin
          // splice the neighbors together
          if (tid_r == head_r) begin
            head_nxt = next_rdata;
          end else begin
            link_ctl.next_we = 1'b1;
            next_waddr       = prev_rdata;
            next_wdata       = next_rdata;
          end
          if (tid_r == tail_r) begin
            tail_nxt = prev_rdata;
          end else begin
            link_ctl.prev_we = 1'b1;
            prev_waddr       = next_rdata;
            prev_wdata       = prev_rdata;
          end
          in_queue_nxt[tid_r] = 1'b0;
          count_nxt           = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      KIND_PICK: begin
        if (count_r != '0) begin
          res.picked_valid     = 1'b1;
          res.picked_id        = TID_W'(head_r);
          in_queue_nxt[head_r] = 1'b0;
          count_nxt            = count_r - CNT_W'(1);
          if (count_r > CNT_W'(1)) begin
            head_nxt = next_rdata;
          end else begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      KIND_TICK: begin
        if (run_valid_r) begin
          if (cnt_inc >= slice_ticks_r) begin
            slice_cnt_nxt  = '0;
            cpu_ctl.acc_en = 1'b1;
            resched_nxt    = 1'b1;
            expired        = 1'b1;
          end else begin
            slice_cnt_nxt = cnt_inc;
          end
        end
      end
      KIND_SET_RUN: begin
        if (!present_r) begin
          run_valid_nxt = 1'b0;
          run_id_nxt    = '0;
        end else if (tid_ok_r) begin
          run_valid_nxt = 1'b1;
          run_id_nxt    = tid_r;
        end
      end
      KIND_RESCHED_SET: resched_nxt = 1'b1;
      KIND_RESCHED_CLR: resched_nxt = 1'b0;
      default: ;
    endcase

    // commit only on the completing cycle
    if (!exec_go) begin
      link_ctl.next_we = 1'b0;
      link_ctl.prev_we = 1'b0;
      cpu_ctl.acc_en   = 1'b0;
    end

    // report fields
    run_time               = expired ? new_time : cur_time;
    res.queued_count       = COUNT_W'(count_nxt);
    res.running_valid      = run_valid_nxt;
    res.running_id         = run_valid_nxt ? TID_W'(run_id_nxt) : '0;
    res.reschedule_pending = resched_nxt;
    res.slice_expired      = expired;
    res.running_cpu_time   = run_valid_nxt ? CPU_OUT_W'(run_time) : '0;
  end

  // sequencer and result register handshake
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      in_queue_r  <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      slice_cnt_r <= '0;
      resched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        count_r     <= count_nxt;
        in_queue_r  <= in_queue_nxt;
        run_valid_r <= run_valid_nxt;
        run_id_r    <= run_id_nxt;
        slice_cnt_r <= slice_cnt_nxt;
        resched_r   <= resched_nxt;
      end
    end
  end

  // captured command and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r    <= in_ch.kind;
      tid_r     <= in_idx;
      tid_ok_r  <= in_tid_ok;
      present_r <= in_ch.task_present;
    end
    if (exec_go) begin
      out_r <= res;
    end
  end

  // configuration register
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SLICE_TICKS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLICE_TICKS)
                  ? {{(APB_DATA_W-SLICE_W){1'b0}}, slice_ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_ticks_r <= SLICE_RESET;
    end else if (cfg_we) begin
      slice_ticks_r <= pwdata[SLICE_W-1:0];
    end
  end

  // result channel
  assign out_ch.valid              = out_valid_r;
  assign out_ch.picked_valid       = out_r.picked_valid;
  assign out_ch.picked_id          = out_r.picked_id;
  assign out_ch.op_ignored         = out_r.op_ignored;
  assign out_ch.queued_count       = out_r.queued_count;
  assign out_ch.running_valid      = out_r.running_valid;
  assign out_ch.running_id         = out_r.running_id;
  assign out_ch.reschedule_pending = out_r.reschedule_pending;
  assign out_ch.slice_expired      = out_r.slice_expired;
  assign out_ch.running_cpu_time   = out_r.running_cpu_time;

  // link tables
  rrts_link_mem #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W)
  ) u_link_mem (
    .clk        (clk),
    .ctl        (link_ctl),
    .next_raddr (next_raddr),
    .prev_raddr (prev_raddr),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata)
  );

  // cpu time table
  rrts_cpu_acct #(
    .MAX_TASKS     (MAX_TASKS),
    .IDX_W         (IDX_W),
    .CPU_TIME_BITS (CPU_TIME_BITS)
  ) u_cpu_acct (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cpu_ctl),
    .raddr    (cpu_raddr),
    .slice    (slice_ticks_r),
    .cur_time (cur_time),
    .new_time (new_time)
  );

endmodule

@@ hw/rtl/rrts_link_mem.sv @@
// ---------------------------------------------------------------------------
// rrts_link_mem
// Next and prev link tables of the ready queue, one synchronous memory each,
// one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module rrts_link_mem #(
  parameter int MAX_TASKS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                clk,
  input  rrts_pkg::link_ctl_t ctl,
  input  logic [IDX_W-1:0]    next_raddr,
  input  logic [IDX_W-1:0]    prev_raddr,
  input  logic [IDX_W-1:0]    next_waddr,
  input  logic [IDX_W-1:0]    next_wdata,
  input  logic [IDX_W-1:0]    prev_waddr,
  input  logic [IDX_W-1:0]    prev_wdata,
  output logic [IDX_W-1:0]    next_rdata,
  output logic [IDX_W-1:0]    prev_rdata
);
  import rrts_pkg::*;

  logic [IDX_W-1:0] next_mem [MAX_TASKS];
  logic [IDX_W-1:0] prev_mem [MAX_TASKS];
  logic [IDX_W-1:0] next_rdata_r;
  logic [IDX_W-1:0] prev_rdata_r;

  // next table
  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctl.rd_en) begin
      next_rdata_r <= next_mem[next_raddr];
    end
  end

  // prev table
  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctl.rd_en) begin
      prev_rdata_r <= prev_mem[prev_raddr];
    end
  end

  assign next_rdata = next_rdata_r;
  assign prev_rdata = prev_rdata_r;

endmodule

@@ hw/rtl/rrts_cpu_acct.sv @@
// ---------------------------------------------------------------------------
// rrts_cpu_acct
// Per-task cpu time table: registered read of one entry, slice accumulate
// and write back to the same entry. Valid bits stand in for the zero reset.
// ---------------------------------------------------------------------------
module rrts_cpu_acct #(
  parameter int MAX_TASKS     = 16,
  parameter int IDX_W         = 4,
  parameter int CPU_TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rrts_pkg::cpu_ctl_t               ctl,
  input  logic [IDX_W-1:0]                 raddr,
  input  logic [rrts_pkg::SLICE_W-1:0]     slice,
  output logic [CPU_TIME_BITS-1:0]         cur_time,
  output logic [CPU_TIME_BITS-1:0]         new_time
);
  import rrts_pkg::*;

  logic [CPU_TIME_BITS-1:0] cpu_mem [MAX_TASKS];
  logic [CPU_TIME_BITS-1:0] rdata_r;
  logic [IDX_W-1:0]         raddr_r;
  logic [MAX_TASKS-1:0]     valid_r;

  // memory read and write back
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      cpu_mem[raddr_r] <= new_time;
    end
    if (ctl.rd_en) begin
      rdata_r <= cpu_mem[raddr];
      raddr_r <= raddr;
    end
  end

  // written-entry flags, a never-written entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.acc_en) begin
      valid_r[raddr_r] <= 1'b1;
    end
  end

  assign cur_time = valid_r[raddr_r] ? rdata_r : '0;
  assign new_time = cur_time + CPU_TIME_BITS'(slice);

endmodule

@@ hw/rtl/rrts_checker.sv @@
// ---------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "round_robin_task_scheduler_core_assert.svh"

module rrts_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           picked_valid,
  input logic [rrts_pkg::TID_W-1:0]     picked_id,
  input logic [rrts_pkg::COUNT_W-1:0]   queued_count,
  input logic                           running_valid,
  input logic [rrts_pkg::TID_W-1:0]     running_id,
  input logic                           reschedule_pending,
  input logic                           slice_expired,
  input logic [rrts_pkg::CPU_OUT_W-1:0] running_cpu_time
);
  import rrts_pkg::*;

  // one command at a time: ready drops after each accepted beat
  `RRTS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // a stalled result beat holds
  `RRTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(picked_id) && $stable(queued_count) && $stable(running_cpu_time))

  // slice expiry only with a running task and raises the reschedule flag
  `RRTS_ASSERT_IMP(a_expiry_flags, clk, rst_n, out_valid && slice_expired,
    running_valid && reschedule_pending)

  // no running task reports zero id and zero cpu time
  `RRTS_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid && !running_valid,
    running_id == '0 && running_cpu_time == '0 && (picked_valid || picked_id == '0))

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .picked_valid       (out_ch.picked_valid),
  .picked_id          (out_ch.picked_id),
  .queued_count       (out_ch.queued_count),
  .running_valid      (out_ch.running_valid),
  .running_id         (out_ch.running_id),
  .reschedule_pending (out_ch.reschedule_pending),
  .slice_expired      (out_ch.slice_expired),
  .running_cpu_time   (out_ch.running_cpu_time)
);

@@ verif/round_robin_task_scheduler_core_tb.sv @@
// ---------------------------------------------------------------------------
// round_robin_task_scheduler_core_tb
// Self-checking bench for the ready-queue scheduler. A directed table walks
// the basic commands and corner cases from reset, then random command
// streams run under several slice lengths. Every result beat is compared
// field by field with its table row or an in-bench model of the queue,
// running task, slice counter and cpu times. Both channels idle at random,
// and the result side holds off for long stretches so the core backs up.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int NUM_TASKS   = 16;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_PRINTS  = 60;
  localparam logic [KIND_W-1:0]     KIND_UNUSED = 3'd7;
  localparam logic [APB_ADDR_W-1:0] SLICE_ADDR  = {REG_SLICE_TICKS, 2'b00};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  task_id;
    logic              task_present;
  } sched_cmd_t;

  typedef struct {
    sched_cmd_t cmd;
    bit         typed;
    result_t    status;
  } directed_row_t;

  typedef struct {
    logic [SLICE_W-1:0] slice;
    int                 count;
    int                 tick_pct;
    bit                 steady;
  } sched_phase_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();

  round_robin_task_scheduler_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scheduler model state
  logic [TID_W-1:0]     next_of [NUM_TASKS];
  logic [TID_W-1:0]     prev_of [NUM_TASKS];
  bit                   is_queued [NUM_TASKS];
  logic [CPU_OUT_W-1:0] cpu_ticks [NUM_TASKS];
  logic [TID_W-1:0]     q_head;
  logic [TID_W-1:0]     q_tail;
  logic [COUNT_W-1:0]   q_count;
  bit                   run_valid;
  logic [TID_W-1:0]     run_id;
  logic [SLICE_W-1:0]   slice_count;
  logic [SLICE_W-1:0]   slice_len;
  bit                   resched;

  result_t       pending_results [$];
  sched_cmd_t    script_q [$];
  directed_row_t directed_rows [$];

  bit steady_flow;
  int fault_count;
  int results_checked;
  int items_sent;
  int n_expired;
  int n_ignored;
  int n_picked;
  int settings_used;
  int kind_hits [8];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_PRINTS) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_fault($sformatf("result beat %0d %s got %0h want %0h",
                             results_checked, name, got, want));
  endtask

  function automatic sched_cmd_t mk_cmd(input logic [KIND_W-1:0] k,
                                        input logic [TID_W-1:0] t, input logic p);
    sched_cmd_t c;
    c.kind = k;
    c.task_id = t;
    c.task_present = p;
    return c;
  endfunction

  function automatic result_t mk_res(input logic pv, input logic [TID_W-1:0] pid,
                                     input logic ign, input logic [COUNT_W-1:0] cnt,
                                     input logic rv, input logic [TID_W-1:0] rid,
                                     input logic rs, input logic ex,
                                     input logic [CPU_OUT_W-1:0] cpu);
    return {pv, pid, ign, cnt, rv, rid, rs, ex, cpu};
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < NUM_TASKS; i++) begin
      next_of[i] = '0;
      prev_of[i] = '0;
      is_queued[i] = 1'b0;
      cpu_ticks[i] = '0;
    end
    q_head = '0;
    q_tail = '0;
    q_count = '0;
    run_valid = 1'b0;
    run_id = '0;
    slice_count = '0;
    slice_len = SLICE_RESET;
    resched = 1'b0;
  endfunction

  // apply one command to the model and return the result beat it causes
  function automatic result_t schedule_step(input sched_cmd_t c);
    result_t r;
    logic [TID_W-1:0] t;
    logic [TID_W-1:0] nx;
    logic [TID_W-1:0] pv;
    r = '0;
    t = c.task_id;
    case (c.kind)
      KIND_ADD: begin
        if (is_queued[t]) begin
          r.op_ignored = 1'b1;
        end else begin
          if (q_count == 0) q_head = t;
          else next_of[q_tail] = t;
          prev_of[t] = q_tail;
          next_of[t] = '0;
          q_tail = t;
          is_queued[t] = 1'b1;
          q_count = q_count + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (!is_queued[t]) begin
          r.op_ignored = 1'b1;
        end else begin
          nx = next_of[t];
          pv = prev_of[t];
          if (t == q_head) q_head = nx;
          else next_of[pv] = nx;
          if (t == q_tail) q_tail = pv;
          else prev_of[nx] = pv;
          is_queued[t] = 1'b0;
          q_count = q_count - 1'b1;
          if (q_count == 0) begin
            q_head = '0;
            q_tail = '0;
          end
        end
      end
      KIND_PICK: begin
        if (q_count != 0) begin
          r.picked_valid = 1'b1;
          r.picked_id = q_head;
          is_queued[q_head] = 1'b0;
          q_count = q_count - 1'b1;
          if (q_count != 0) begin
            q_head = next_of[q_head];
          end else begin
            q_head = '0;
            q_tail = '0;
          end
        end
      end
      KIND_TICK: begin
        if (run_valid) begin
          slice_count = slice_count + 1'b1;
          // lowered or zero slice length expires at once
          if (slice_count >= slice_len) begin
            slice_count = '0;
            cpu_ticks[run_id] = cpu_ticks[run_id] + CPU_OUT_W'(slice_len);
            resched = 1'b1;
            r.slice_expired = 1'b1;
          end
        end
      end
      KIND_SET_RUN: begin
        run_valid = c.task_present;
        run_id = c.task_present ? t : '0;
      end
      KIND_RESCHED_SET: resched = 1'b1;
      KIND_RESCHED_CLR: resched = 1'b0;
      default: ;
    endcase
    r.queued_count = q_count;
    r.running_valid = run_valid;
    r.running_id = run_valid ? run_id : '0;
    r.reschedule_pending = resched;
    r.running_cpu_time = run_valid ? cpu_ticks[run_id] : '0;
    return r;
  endfunction

  // mostly short gaps, a few long ones, none while flow is steady
  function automatic int idle_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next random command, shaped like a scheduler at work around some noise
  task automatic next_cmd(input int tick_pct, output sched_cmd_t c);
    int r;
    int steps;
    logic [TID_W-1:0] walk;
    logic [TID_W-1:0] rt;
    logic rp;
    rt = TID_W'($urandom);
    rp = 1'($urandom);
    c = mk_cmd(KIND_W'($urandom_range(0, 7)), rt, rp);
    if (script_q.size() != 0) begin
      c = script_q.pop_front();
    end else if (resched && run_valid && $urandom_range(0, 3) != 0) begin
      // context switch: requeue the running task, run the head, clear the flag
      walk = (q_count != 0) ? q_head : run_id;
      c = mk_cmd(KIND_ADD, run_id, rp);
      script_q.push_back(mk_cmd(KIND_PICK, rt, rp));
      script_q.push_back(mk_cmd(KIND_SET_RUN, walk, 1'b1));
      script_q.push_back(mk_cmd(KIND_RESCHED_CLR, rt, rp));
    end else if (!run_valid && $urandom_range(0, 2) == 0) begin
      // nothing runs: dispatch the head, or any task if the queue is empty
      if (q_count != 0) begin
        c = mk_cmd(KIND_PICK, rt, rp);
        script_q.push_back(mk_cmd(KIND_SET_RUN, q_head, 1'b1));
      end else begin
        c = mk_cmd(KIND_SET_RUN, rt, 1'b1);
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        c.kind = KIND_TICK;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          c.kind = KIND_ADD;
        end else if (r < 55) begin
          c.kind = KIND_REMOVE;
          // half of the removes hit a queued task at head, middle or tail
          if (q_count != 0 && $urandom_range(0, 1) == 1) begin
            walk = q_head;
            steps = $urandom_range(0, q_count - 1);
            repeat (steps) walk = next_of[walk];
            c.task_id = walk;
          end
        end else if (r < 65) begin
          c.kind = KIND_PICK;
        end else if (r < 75) begin
          c.kind = KIND_SET_RUN;
        end else if (r < 83) begin
          c.kind = KIND_RESCHED_SET;
        end else if (r < 91) begin
          c.kind = KIND_RESCHED_CLR;
        end else if (r < 95) begin
          c.kind = KIND_UNUSED;
        end
      end
    end
  endtask

  // offer one command beat, then book its expected result on acceptance
  task automatic send_cmd(input sched_cmd_t c, input bit typed, input result_t status);
    int gap;
    result_t predicted;
    gap = idle_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= c.kind;
    in_ch.task_id <= c.task_id;
    in_ch.task_present <= c.task_present;
    do @(posedge clk); while (!in_ch.ready);
    predicted = schedule_step(c);
    pending_results.push_back(typed ? status : predicted);
    items_sent++;
    kind_hits[c.kind]++;
    n_expired += predicted.slice_expired;
    n_ignored += predicted.op_ignored;
    n_picked += predicted.picked_valid;
  endtask

  // stop offering and wait for every booked result
  task automatic end_phase();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_slice(input logic [SLICE_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    apb_xfer(1'b1, SLICE_ADDR, APB_DATA_W'(v), rd);
    apb_xfer(1'b0, SLICE_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(v))
      report_fault($sformatf("slice_ticks read back %0h after writing %0h", rd, v));
    slice_len = v;
    settings_used++;
  endtask

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [TID_W-1:0] t,
                         input logic p, input bit typed, input result_t status);
    directed_row_t row;
    row.cmd = mk_cmd(k, t, p);
    row.typed = typed;
    row.status = status;
    directed_rows.push_back(row);
  endtask

  // result side: random stalls plus two long hold-offs
  initial begin : result_sink
    int taken;
    int stall;
    taken = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 150 || taken == 900) stall = HOLD_CYCLES;
      else stall = idle_gap();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.picked_valid, out_ch.picked_id, out_ch.op_ignored,
             out_ch.queued_count, out_ch.running_valid, out_ch.running_id,
             out_ch.reschedule_pending, out_ch.slice_expired, out_ch.running_cpu_time};
      if (pending_results.size() == 0) begin
        report_fault($sformatf("result beat %0d arrived with nothing expected",
                               results_checked));
      end else begin
        want = pending_results.pop_front();
        check_field("picked_valid", 32'(got.picked_valid), 32'(want.picked_valid));
        check_field("picked_id", 32'(got.picked_id), 32'(want.picked_id));
        check_field("op_ignored", 32'(got.op_ignored), 32'(want.op_ignored));
        check_field("queued_count", 32'(got.queued_count), 32'(want.queued_count));
        check_field("running_valid", 32'(got.running_valid), 32'(want.running_valid));
        check_field("running_id", 32'(got.running_id), 32'(want.running_id));
        check_field("reschedule_pending", 32'(got.reschedule_pending),
                    32'(want.reschedule_pending));
        check_field("slice_expired", 32'(got.slice_expired), 32'(want.slice_expired));
        check_field("running_cpu_time", got.running_cpu_time, want.running_cpu_time);
      end
      results_checked++;
    end
  end

  // end the run when no beat moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: %0d cycles without a beat", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    sched_phase_t phases [$];
    sched_cmd_t c;
    logic [APB_DATA_W-1:0] rd;
    result_t zero_res;
    // known values on every input from time zero
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= '0;
    in_ch.task_id <= '0;
    in_ch.task_present <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady_flow = 1'b0;
    fault_count = 0;
    results_checked = 0;
    items_sent = 0;
    n_expired = 0;
    n_ignored = 0;
    n_picked = 0;
    settings_used = 0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    zero_res = '0;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slice length comes up at its reset value
    apb_xfer(1'b0, SLICE_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(SLICE_RESET))
      report_fault($sformatf("slice_ticks reads %0h after reset", rd));

    // directed table, reset slice length of ten
    add_row(KIND_TICK, 4'd0, 1'b0, 1, zero_res);
    add_row(KIND_PICK, 4'd15, 1'b1, 1, zero_res);
    add_row(KIND_REMOVE, 4'd5, 1'b0, 1, mk_res(0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(KIND_UNUSED, 4'd15, 1'b1, 1, zero_res);
    add_row(KIND_ADD, 4'd0, 1'b0, 1, mk_res(0, 0, 0, 1, 0, 0, 0, 0, 0));
    add_row(KIND_ADD, 4'd15, 1'b1, 1, mk_res(0, 0, 0, 2, 0, 0, 0, 0, 0));
    add_row(KIND_ADD, 4'd0, 1'b1, 1, mk_res(0, 0, 1, 2, 0, 0, 0, 0, 0));
    add_row(KIND_ADD, 4'd7, 1'b0, 1, mk_res(0, 0, 0, 3, 0, 0, 0, 0, 0));
    add_row(KIND_REMOVE, 4'd15, 1'b1, 1, mk_res(0, 0, 0, 2, 0, 0, 0, 0, 0));
    add_row(KIND_REMOVE, 4'd15, 1'b0, 1, mk_res(0, 0, 1, 2, 0, 0, 0, 0, 0));
    add_row(KIND_PICK, 4'd3, 1'b0, 1, mk_res(1, 0, 0, 1, 0, 0, 0, 0, 0));
    add_row(KIND_SET_RUN, 4'd0, 1'b1, 1, mk_res(0, 0, 0, 1, 1, 0, 0, 0, 0));
    add_row(KIND_RESCHED_SET, 4'd9, 1'b0, 1, mk_res(0, 0, 0, 1, 1, 0, 1, 0, 0));
    add_row(KIND_RESCHED_CLR, 4'd6, 1'b1, 1, mk_res(0, 0, 0, 1, 1, 0, 0, 0, 0));
    repeat (9) add_row(KIND_TICK, 4'd11, 1'b1, 0, zero_res);
    add_row(KIND_TICK, 4'd0, 1'b0, 1, mk_res(0, 0, 0, 1, 1, 0, 1, 1, 10));
    add_row(KIND_SET_RUN, 4'd9, 1'b0, 1, mk_res(0, 0, 0, 1, 0, 0, 1, 0, 0));
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].status);
    end_phase();

    // random phases: longest slice first so the drop to one hits a high counter
    phases.push_back('{8'd255, 380, 80, 1'b0});
    phases.push_back('{8'd1, 180, 40, 1'b0});
    phases.push_back('{8'd0, 120, 40, 1'b1});
    phases.push_back('{8'd5, 250, 45, 1'b0});
    phases.push_back('{SLICE_W'($urandom_range(2, 40)), 220, 45, 1'b0});
    phases.push_back('{8'd3, 200, 45, 1'b1});
    phases.push_back('{8'd2, 200, 45, 1'b0});
    foreach (phases[p]) begin
      set_slice(phases[p].slice);
      steady_flow = phases[p].steady;
      repeat (phases[p].count) begin
        next_cmd(phases[p].tick_pct, c);
        send_cmd(c, 1'b0, zero_res);
      end
      end_phase();
    end
    steady_flow = 1'b0;
    repeat (4) @(posedge clk);

    $display("%0d commands over %0d slice settings: %0d add, %0d remove, %0d pick, %0d tick",
             items_sent, settings_used, kind_hits[KIND_ADD], kind_hits[KIND_REMOVE],
             kind_hits[KIND_PICK], kind_hits[KIND_TICK]);
    $display("%0d results checked: %0d slice expiries, %0d picks, %0d ignored, %0d faults",
             results_checked, n_expired, n_picked, n_ignored, fault_count);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_if.sv
hw/rtl/rrts_link_mem.sv
hw/rtl/rrts_cpu_acct.sv
hw/rtl/round_robin_task_scheduler_core.sv
hw/rtl/rrts_checker.sv
verif/round_robin_task_scheduler_core_tb.sv
